// ----- hw/rtl/ecal_pkg.sv -----
// Shared constants, types and helpers of the epoch-seconds to calendar converter.
package ecal_pkg;

  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned MinsPerHour   = 60;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned DaysPerBlock  = 1461;
  localparam int unsigned HoursPerBlock = DaysPerBlock * HoursPerDay;
  localparam int unsigned HoursPerYear  = 365 * HoursPerDay;
  localparam int unsigned BaseYear      = 1970;
  localparam int unsigned YearFold      = 2000;
  localparam int unsigned LeapDay       = 60;
  localparam int unsigned LastMonth     = 11;

  localparam int unsigned DivW  = 32;  // widest dividend
  localparam int unsigned RemW  = 16;  // holds every divisor and remainder
  localparam int unsigned CntW  = 6;   // counts up to DivW quotient bits
  localparam int unsigned IdxW  = 5;   // bit index into the dividend
  localparam int unsigned BlkW  = 6;   // four-year blocks, at most 34
  localparam int unsigned YearW = 12;  // calendar year, up to 2106
  localparam int unsigned DayW  = 9;   // day of year, 1..366

  // quotient widths of the successive divisions
  localparam logic [CntW-1:0] NbitsSec  = 6'd32;
  localparam logic [CntW-1:0] NbitsMin  = 6'd27;
  localparam logic [CntW-1:0] NbitsBlk  = 6'd21;
  localparam logic [CntW-1:0] NbitsHour = 6'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_BLK,
    S_YEAR,
    S_HOUR,
    S_MPREP,
    S_MONTH,
    S_FIN
  } state_e;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] nbits;
    logic [RemW-1:0] divisor;
    logic [DivW-1:0] dividend;
  } div_cmd_t;

  typedef struct packed {
    logic            load_year;
    logic [BlkW-1:0] blocks;
    logic [RemW-1:0] hours;
    logic            step_year;
    logic            load_day;
    logic [DayW-1:0] day;
    logic            prep;
    logic            step_month;
  } cal_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } cal_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/ecal_sdiv.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
module ecal_sdiv import ecal_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_cmd_t        cmd_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o,
  output logic [RemW-1:0] rem_o
);

  logic [DivW-1:0] val_q, val_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [IdxW-1:0] idx;
  logic [RemW:0]   trial;
  logic [RemW:0]   diff;
  logic            ge;

  assign idx   = IdxW'(cnt_q - CntW'(1));
  assign trial = {rem_q, val_q[idx]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      val_d = cmd_i.dividend;
      rem_d = '0;
      dvs_d = cmd_i.divisor;
      cnt_d = cmd_i.nbits;
      run_d = 1'b1;
    end else if (run_q) begin
      // quotient bit replaces the dividend bit just consumed
      val_d[idx] = ge;
      rem_d      = ge ? diff[RemW-1:0] : trial[RemW-1:0];
      cnt_d      = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = val_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/ecal_cal.sv -----
// Year and month stepper: one year or one month per cycle.
module ecal_cal import ecal_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cal_cmd_t        cmd_i,
  output cal_sts_t        sts_o,
  output logic [RemW-1:0] hours_o,
  output logic [4:0]      day_o,
  output logic [3:0]      month_o,
  output logic [10:0]     year_code_o
);

  logic [YearW-1:0] year_q, year_d;
  logic [RemW-1:0]  hrs_q, hrs_d;
  logic [DayW-1:0]  day_q, day_d;
  logic [3:0]       month_q, month_d;
  logic             fix_q, fix_d;
  logic             leap;
  logic [RemW-1:0]  ylen;
  logic [4:0]       mlen;
  logic             year_done;
  logic             month_done;

  assign leap       = year_q[1:0] == 2'b00;
  assign ylen       = leap ? RemW'(HoursPerYear + HoursPerDay) : RemW'(HoursPerYear);
  assign mlen       = month_len(month_q);
  assign year_done  = hrs_q < ylen;
  assign month_done = fix_q || (month_q == 4'(LastMonth)) || (day_q <= {4'd0, mlen});

  always_comb begin
    year_d  = year_q;
    hrs_d   = hrs_q;
    day_d   = day_q;
    month_d = month_q;
    fix_d   = fix_q;
    if (cmd_i.load_year) begin
      year_d = YearW'(BaseYear) + {4'd0, cmd_i.blocks, 2'b00};
      hrs_d  = cmd_i.hours;
    end else if (cmd_i.step_year && !year_done) begin
      hrs_d  = hrs_q - ylen;
      year_d = year_q + YearW'(1);
    end
    if (cmd_i.load_day) begin
      day_d   = cmd_i.day;
      month_d = '0;
      fix_d   = 1'b0;
    end else if (cmd_i.prep) begin
      // February 29 settles at once; later leap-year days drop it
      if (leap && day_q == DayW'(LeapDay)) begin
        month_d = 4'd1;
        day_d   = DayW'(29);
        fix_d   = 1'b1;
      end else if (leap && day_q > DayW'(LeapDay)) begin
        day_d = day_q - DayW'(1);
      end
    end else if (cmd_i.step_month && !month_done) begin
      day_d   = day_q - {4'd0, mlen};
      month_d = month_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q <= 1'b0;
    end else begin
      fix_q <= fix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    hrs_q   <= hrs_d;
    day_q   <= day_d;
    month_q <= month_d;
  end

  assign sts_o.year_done  = year_done;
  assign sts_o.month_done = month_done;
  assign hours_o          = hrs_q;
  assign day_o            = day_q[4:0];
  assign month_o          = month_q;
  assign year_code_o      = (year_q >= YearW'(YearFold)) ? 11'(year_q - YearW'(YearFold))
                                                         : year_q[10:0];

endmodule

// ----- hw/rtl/epoch_seconds_to_calendar_unit.sv -----
// Top level: sequences the serial divider and the calendar stepper.
// Each request runs the seconds, minutes and four-year-block divisions on the serial divider,
// then up to 3 year steps, the hour division, the leap-day fix and up to 11 month steps.
// One request is in flight at a time; the next request is taken while a
// finished result waits in the output register.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module epoch_seconds_to_calendar_unit import ecal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  seconds_part_o,
  output logic [5:0]  minutes_part_o,
  output logic [4:0]  hours_part_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_index_o,
  output logic [10:0] year_code_o
);

  state_e          state_q, state_d;
  div_cmd_t        div_cmd;
  cal_cmd_t        cal_cmd;
  cal_sts_t        cal_sts;
  logic            div_done;
  logic [DivW-1:0] div_quot;
  logic [RemW-1:0] div_rem;
  logic [RemW-1:0] cal_hours;
  logic [4:0]      cal_day;
  logic [3:0]      cal_month;
  logic [10:0]     cal_year;
  logic            in_acc;
  logic            cap_sec, cap_min, cap_hour, out_load;
  logic [5:0]      sec_q, min_q;
  logic [4:0]      hour_q;
  logic            out_valid_q, out_valid_d;
  logic [5:0]      o_sec_q, o_min_q;
  logic [4:0]      o_hour_q, o_day_q;
  logic [3:0]      o_month_q;
  logic [10:0]     o_year_q;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  ecal_sdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  ecal_cal u_cal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cal_cmd),
    .sts_o       (cal_sts),
    .hours_o     (cal_hours),
    .day_o       (cal_day),
    .month_o     (cal_month),
    .year_code_o (cal_year)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SEC;
      S_SEC:   if (div_done) state_d = S_MIN;
      S_MIN:   if (div_done) state_d = S_BLK;
      S_BLK:   if (div_done) state_d = S_YEAR;
      S_YEAR:  if (cal_sts.year_done) state_d = S_HOUR;
      S_HOUR:  if (div_done) state_d = S_MPREP;
      S_MPREP: state_d = S_MONTH;
      S_MONTH: if (cal_sts.month_done) state_d = S_FIN;
      S_FIN:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    div_cmd  = '0;
    cal_cmd  = '0;
    cap_sec  = 1'b0;
    cap_min  = 1'b0;
    cap_hour = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        div_cmd.start    = in_acc;
        div_cmd.nbits    = NbitsSec;
        div_cmd.divisor  = RemW'(SecsPerMin);
        div_cmd.dividend = epoch_seconds_i;
      end
      S_SEC: begin
        cap_sec          = div_done;
        div_cmd.start    = div_done;
        div_cmd.nbits    = NbitsMin;
        div_cmd.divisor  = RemW'(MinsPerHour);
        div_cmd.dividend = div_quot;
      end
      S_MIN: begin
        cap_min          = div_done;
        div_cmd.start    = div_done;
        div_cmd.nbits    = NbitsBlk;
        div_cmd.divisor  = RemW'(HoursPerBlock);
        div_cmd.dividend = div_quot;
      end
      S_BLK: begin
        cal_cmd.load_year = div_done;
        cal_cmd.blocks    = div_quot[BlkW-1:0];
        cal_cmd.hours     = div_rem;
      end
      S_YEAR: begin
        // advance one year per cycle, then split hours into day and hour
        cal_cmd.step_year = 1'b1;
        div_cmd.start     = cal_sts.year_done;
        div_cmd.nbits     = NbitsHour;
        div_cmd.divisor   = RemW'(HoursPerDay);
        div_cmd.dividend  = {{(DivW-RemW){1'b0}}, cal_hours};
      end
      S_HOUR: begin
        cap_hour         = div_done;
        cal_cmd.load_day = div_done;
        cal_cmd.day      = div_quot[DayW-1:0] + DayW'(1);
      end
      S_MPREP: cal_cmd.prep = 1'b1;
      S_MONTH: cal_cmd.step_month = 1'b1;
      S_FIN:   out_load = !out_valid_q || !out_stall_i;
      default: out_load = 1'b0;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_sec) sec_q <= div_rem[5:0];
    if (cap_min) min_q <= div_rem[5:0];
    if (cap_hour) hour_q <= div_rem[4:0];
    if (out_load) begin
      o_sec_q   <= sec_q;
      o_min_q   <= min_q;
      o_hour_q  <= hour_q;
      o_day_q   <= cal_day;
      o_month_q <= cal_month;
      o_year_q  <= cal_year;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign seconds_part_o = o_sec_q;
  assign minutes_part_o = o_min_q;
  assign hours_part_o   = o_hour_q;
  assign day_of_month_o = o_day_q;
  assign month_index_o  = o_month_q;
  assign year_code_o    = o_year_q;

endmodule

// ----- hw/rtl/ecal_checker.sv -----
// Port-level checker for the converter and its bind to the top level.
module ecal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  seconds_part_o,
  input logic [5:0]  minutes_part_o,
  input logic [4:0]  hours_part_o,
  input logic [4:0]  day_of_month_o,
  input logic [3:0]  month_index_o,
  input logic [10:0] year_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(year_code_o) && $stable(day_of_month_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seconds_part_o < 6'd60 && minutes_part_o < 6'd60 && hours_part_o < 5'd24)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_index_o < 4'd12 && day_of_month_o != 5'd0 &&
                    (month_index_o != 4'd1 || day_of_month_o < 5'd30))
    else $error("date out of range");

endmodule

bind epoch_seconds_to_calendar_unit ecal_checker u_ecal_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .seconds_part_o (seconds_part_o),
  .minutes_part_o (minutes_part_o),
  .hours_part_o   (hours_part_o),
  .day_of_month_o (day_of_month_o),
  .month_index_o  (month_index_o),
  .year_code_o    (year_code_o)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the epoch-seconds to calendar converter, streamed requests.
module tb;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned MaxPrinted  = 50;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned HoursInYear = 365 * 24;
  localparam int unsigned HoursInQuad = 1461 * 24;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [10:0] year;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_secs = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  seconds_part;
  logic [5:0]  minutes_part;
  logic [4:0]  hours_part;
  logic [4:0]  day_of_month;
  logic [3:0]  month_index;
  logic [10:0] year_code;

  calendar_t   pending_dates[$];
  int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_len = 0;
  int unsigned hold_left = 0;

  epoch_seconds_to_calendar_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .epoch_seconds_i (epoch_secs),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .seconds_part_o  (seconds_part),
    .minutes_part_o  (minutes_part),
    .hours_part_o    (hours_part),
    .day_of_month_o  (day_of_month),
    .month_index_o   (month_index),
    .year_code_o     (year_code)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("epoch_seconds_to_calendar_unit verification failed");
      $finish;
    end
  end

  // Every year divisible by four is leap, 2100 included; year folds at 2000.
  function automatic calendar_t to_calendar(input logic [31:0] secs);
    calendar_t   c;
    int unsigned t;
    int unsigned yr;
    int unsigned len;
    int unsigned day_no;
    int unsigned mon;
    bit          leap;
    c.sec = 6'(secs % 60);
    t = secs / 60;
    c.min = 6'(t % 60);
    t = t / 60;
    yr = 1970 + 4 * (t / HoursInQuad);
    t = t % HoursInQuad;
    len = HoursInYear + ((yr % 4 == 0) ? 24 : 0);
    while (t >= len) begin
      t -= len;
      yr++;
      len = HoursInYear + ((yr % 4 == 0) ? 24 : 0);
    end
    c.hour = 5'(t % 24);
    day_no = t / 24 + 1;
    leap = (yr % 4 == 0);
    mon = 0;
    if (leap && day_no == 60) begin
      mon = 1;
      c.mday = 5'd29;
    end else begin
      if (leap && day_no > 60) day_no--;
      while (mon < 11 && day_no > month_days[mon]) begin
        day_no -= month_days[mon];
        mon++;
      end
      c.mday = 5'(day_no);
    end
    c.mon = 4'(mon);
    c.year = 11'(yr % 2000);
    return c;
  endfunction

  function automatic longint unsigned year_start(input int unsigned yr);
    return longint'((yr - 1970) * 365 + (yr - 1) / 4 - 492) * SecsPerDay;
  endfunction

  // Mix of uniform values and dates crowded around leap days, year edges and day edges.
  function automatic logic [31:0] pick_epoch();
    longint unsigned s;
    int unsigned     yr;
    int unsigned     sod;
    case ($urandom_range(0, 4))
      0, 1: s = $urandom;
      2: begin
        yr = 1972 + 4 * $urandom_range(0, 33);
        s = year_start(yr) + (58 + $urandom_range(0, 2)) * SecsPerDay
            + $urandom_range(0, SecsPerDay - 1);
      end
      3: begin
        yr = $urandom_range(1971, 2106);
        s = year_start(yr) - 2 * SecsPerDay + $urandom_range(0, 4 * SecsPerDay);
      end
      default: begin
        yr = $urandom_range(1970, 2105);
        case ($urandom_range(0, 2))
          0: sod = 0;
          1: sod = SecsPerDay - 1;
          default: sod = $urandom_range(0, SecsPerDay - 1);
        endcase
        s = year_start(yr) + $urandom_range(0, 365) * SecsPerDay + sod;
      end
    endcase
    return s[31:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("MISMATCH t=%0t %s: expected %0d got %0d", $time, what, exp_v, got_v);
  endtask

  // Offer one request, idling first as the current gap rate says; return once taken.
  task automatic send_request(input logic [31:0] secs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    epoch_secs <= secs;
    do @(posedge clk_i); while (in_stall);
    pending_dates.push_back(to_calendar(secs));
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_request(pick_epoch());
  endtask

  // Long receiver hold-off: load the requested stretch, then count it down.
  always @(posedge clk_i) begin
    if (hold_off_len != 0) begin
      hold_left <= hold_off_len;
      hold_off_len = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receive side: check each result, then pick the next stall.
  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with no request outstanding", 0, 1);
      end else begin
        want = pending_dates.pop_front();
        if (seconds_part !== want.sec) report_mismatch("seconds_part", want.sec, seconds_part);
        if (minutes_part !== want.min) report_mismatch("minutes_part", want.min, minutes_part);
        if (hours_part !== want.hour) report_mismatch("hours_part", want.hour, hours_part);
        if (day_of_month !== want.mday)
          report_mismatch("day_of_month", want.mday, day_of_month);
        if (month_index !== want.mon) report_mismatch("month_index", want.mon, month_index);
        if (year_code !== want.year) report_mismatch("year_code", want.year, year_code);
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic test_directed_dates();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(32'd0);
    send_request(32'hFFFF_FFFF);
    send_request(32'hAAAA_AAAA);
    send_request(32'h5555_5555);
    send_request(32'd59);
    send_request(32'd60);
    send_request(32'd3599);
    send_request(32'd3600);
    send_request(32'd86399);
    send_request(32'd86400);
    send_request(32'd31535999);     // last second of 1970
    send_request(32'd31536000);
    send_request(32'd68169599);     // 1972, day before leap day
    send_request(32'd68169600);     // leap day itself
    send_request(32'd68256000);     // March 1 after a leap day
    send_request(32'd94694399);     // end of a leap year
    send_request(32'd126230400);    // first four-year block boundary
    send_request(32'd946684799);    // last second before the year fold
    send_request(32'd946684800);
    send_request(32'd951825600);    // leap day 2000
    send_request(32'd4107542399);   // 2100, wrongly leap from here on
    send_request(32'd4107542400);
    send_request(32'd2147483647);
    send_request(32'd2147483648);
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(350);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 61;
    recv_stall_pct = 0;
    send_random(340);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    send_random(340);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(340);
  endtask

  // Hold the output off long enough that the unit fills and stalls its input.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_len = 600;
    send_random(12);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_dates();
    test_streaming();
    test_backpressure_fill();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("epoch_seconds_to_calendar_unit verification clean");
    end else begin
      $display("epoch_seconds_to_calendar_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ecal_pkg.sv
hw/rtl/ecal_sdiv.sv
hw/rtl/ecal_cal.sv
hw/rtl/epoch_seconds_to_calendar_unit.sv
hw/rtl/ecal_checker.sv
tb/sv/tb.sv
